/* rtl/spq_pkg.sv */
// package for the stable priority queue: field widths, request and status codes,
// default sizes and the controller-to-datapath command struct
// no dependencies
package spq_pkg;

    localparam int PAYLOAD_W         = 32;
    localparam int PRIO_PORT_W       = 8;
    localparam int STATUS_W          = 2;
    localparam int OCC_W             = 5;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int PRIORITY_BITS_DEF = 8;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic load_req;
        logic exec;
    } spq_cmd_t;

endpackage

/* rtl/spq_if.sv */
// request and response channel interfaces for the stable priority queue
// depends on spq_pkg
interface spq_req_if import spq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [PRIO_PORT_W-1:0] priority_req;
    logic [PAYLOAD_W-1:0]   payload;

    modport source (output valid, output req_type, output priority_req, output payload,
                    input ready);
    modport sink   (input valid, input req_type, input priority_req, input payload,
                    output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [PAYLOAD_W-1:0]   out_payload;
    logic [PRIO_PORT_W-1:0] out_priority;
    logic [OCC_W-1:0]       occupancy;

    modport source (output valid, output status, output out_payload, output out_priority,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_payload, input out_priority,
                    input occupancy, output ready);
endinterface

/* rtl/stable_priority_queue_top.sv */
// top level of the stable priority queue: sorted entry array with a
// request channel and a response channel
// depends on spq_pkg, spq_if, spq_ctrl and spq_datapath
//
// usage:
//   req channel carries req_type (enqueue or dequeue), priority_req and
//   payload; rsp channel returns status, out_payload, out_priority and the
//   occupancy after the request. every request gives exactly one response.
//   an enqueue goes behind all stored entries of greater or equal priority,
//   so higher priorities leave first and equal ones leave in arrival order.
//   an enqueue into a full queue is dropped with status full; a dequeue on
//   an empty queue returns status empty with zero payload and priority.
// timing:
//   a request is taken in idle and executed in the next cycle unless the response
//   register is held; no new request is taken until it executes. all entries
//   compare and shift at execute; the response is valid the cycle after that.
// reset:
//   the queue comes up empty; stored entries need no clearing.
// stall:
//   a held response does not block taking the next request; that request
//   waits in the execute step until the response register is free.
module stable_priority_queue_top import spq_pkg::*; #(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    spq_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req.req_type),
        .priority_req (req.priority_req),
        .payload      (req.payload),
        .status       (rsp.status),
        .out_payload  (rsp.out_payload),
        .out_priority (rsp.out_priority),
        .occupancy    (rsp.occupancy)
    );

endmodule

/* rtl/spq_datapath.sv */
// datapath of the stable priority queue: request register, sorted entry array
// with parallel compare and shift, entry count and result register
// depends on spq_pkg
module spq_datapath import spq_pkg::*; #(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spq_cmd_t               cmd,
    input  logic                   req_type,
    input  logic [PRIO_PORT_W-1:0] priority_req,
    input  logic [PAYLOAD_W-1:0]   payload,
    output logic [STATUS_W-1:0]    status,
    output logic [PAYLOAD_W-1:0]   out_payload,
    output logic [PRIO_PORT_W-1:0] out_priority,
    output logic [OCC_W-1:0]       occupancy
);

    localparam int PW    = PRIORITY_BITS;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                   req_type_reg;
    logic [PW-1:0]          prio_q_reg;
    logic [PAYLOAD_W-1:0]   payload_reg;

    logic [PW-1:0]          prio_reg [QUEUE_DEPTH];
    logic [PAYLOAD_W-1:0]   data_reg [QUEUE_DEPTH];
    logic [PW-1:0]          prio_next [QUEUE_DEPTH];
    logic [PAYLOAD_W-1:0]   data_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic [STATUS_W-1:0]    status_reg;
    logic [PAYLOAD_W-1:0]   out_payload_reg;
    logic [PRIO_PORT_W-1:0] out_priority_reg;

    logic [PW+PRIO_PORT_W-1:0]    prio_in_wide;
    logic [PW+PRIO_PORT_W-1:0]    prio_out_wide;
    logic [CNT_W+OCC_W-1:0]       count_wide;
    logic [QUEUE_DEPTH-1:0]       ge;
    logic [QUEUE_DEPTH-1:0]       ge_prev;
    logic                         full;
    logic                         empty;
    logic                         do_enq;
    logic                         do_deq;

    // keep only the low priority bits of the request
    assign prio_in_wide  = {{PW{1'b0}}, priority_req};
    assign prio_out_wide = {{PRIO_PORT_W{1'b0}}, prio_reg[0]};
    assign count_wide    = {{OCC_W{1'b0}}, count_reg};

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_enq = cmd.exec && (req_type_reg == REQ_ENQ) && !full;
    assign do_deq = cmd.exec && (req_type_reg == REQ_DEQ) && !empty;

    // entries with priority >= new one form a prefix of the sorted array
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            ge[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] >= prio_q_reg);
        end
        ge_prev[0] = 1'b1;
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            ge_prev[i] = ge[i-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            prio_next[i] = prio_reg[i];
            data_next[i] = data_reg[i];
        end
        count_next = count_reg;
        if (do_enq)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (!ge[i] && ge_prev[i])
                begin
                    prio_next[i] = prio_q_reg;
                    data_next[i] = payload_reg;
                end
            end
            // entries past the insert point move back one slot
            for (int i = 1; i < QUEUE_DEPTH; i++)
            begin
                if (!ge[i] && !ge_prev[i])
                begin
                    prio_next[i] = prio_reg[i-1];
                    data_next[i] = data_reg[i-1];
                end
            end
            count_next = count_reg + 1'b1;
        end
        else if (do_deq)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                prio_next[i] = prio_reg[i+1];
                data_next[i] = data_reg[i+1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            prio_reg[i] <= prio_next[i];
            data_reg[i] <= data_next[i];
        end
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            prio_q_reg   <= prio_in_wide[PW-1:0];
            payload_reg  <= payload;
        end
        if (cmd.exec)
        begin
            if (req_type_reg == REQ_ENQ)
            begin
                status_reg       <= full ? ST_FULL : ST_DONE;
                out_payload_reg  <= '0;
                out_priority_reg <= '0;
            end
            else if (empty)
            begin
                status_reg       <= ST_EMPTY;
                out_payload_reg  <= '0;
                out_priority_reg <= '0;
            end
            else
            begin
                status_reg       <= ST_DONE;
                out_payload_reg  <= data_reg[0];
                out_priority_reg <= prio_out_wide[PRIO_PORT_W-1:0];
            end
        end
    end

    // count only changes at exec, so it still matches the held result
    assign status       = status_reg;
    assign out_payload  = out_payload_reg;
    assign out_priority = out_priority_reg;
    assign occupancy    = count_wide[OCC_W-1:0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_enq |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted enqueue did not grow the count");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_deq |=> count_reg == $past(count_reg) - 1'b1)
        else $error("dequeue did not shrink the count");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> prio_reg[0] >= prio_reg[1])
        else $error("head entry not the highest priority");

endmodule

/* rtl/spq_ctrl.sv */
// controller of the stable priority queue: takes a request, issues the
// execute step once the result register is free, tracks result valid
// depends on spq_pkg
module spq_ctrl import spq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output spq_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load_req = 1'b0;
        cmd.exec     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait here while the previous result is still held
                if (slot_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("execute step left no result");

    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_req |=> state_reg == S_EXEC && !in_ready)
        else $error("request taken without moving to execute");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !cmd.exec)
        else $error("held result overwritten");

endmodule

/* tb/sv/spq_checker.sv */
// response checker for the stable priority queue: keeps a sorted shadow of the
// stored entries, predicts each response and compares it with the rsp channel
// depends on spq_pkg and spq_if
module spq_checker import spq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    spq_req_if   req_mon,
    spq_rsp_if   rsp_mon,
    output int   mismatch_count,
    output int   responses_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PRIO_PORT_W-1:0] PRIO_MASK = PRIO_PORT_W'((1 << PRIORITY_BITS_DEF) - 1);

    typedef struct {
        logic [PRIO_PORT_W-1:0] prio;
        logic [PAYLOAD_W-1:0]   data;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [PAYLOAD_W-1:0]   data;
        logic [PRIO_PORT_W-1:0] prio;
        logic [OCC_W-1:0]       occ;
    } response_t;

    entry_t    shadow_entries[$];
    response_t owed_responses[$];

    initial
    begin
        mismatch_count = 0;
        responses_owed = 0;
    end

    function automatic response_t apply_request(input logic kind,
                                                input logic [PRIO_PORT_W-1:0] prio_in,
                                                input logic [PAYLOAD_W-1:0] data_in);
        response_t r;
        entry_t    e;
        int        pos;
        r = '0;
        if (kind == REQ_ENQ)
        begin
            if (shadow_entries.size() >= QUEUE_DEPTH_DEF)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                e.prio = prio_in & PRIO_MASK;
                e.data = data_in;
                // new entry goes behind every entry of greater or equal priority
                pos = 0;
                while (pos < shadow_entries.size() && shadow_entries[pos].prio >= e.prio)
                    pos++;
                shadow_entries.insert(pos, e);
                r.status = ST_DONE;
            end
        end
        else
        begin
            if (shadow_entries.size() == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                e = shadow_entries.pop_front();
                r.status = ST_DONE;
                r.data   = e.data;
                r.prio   = e.prio;
            end
        end
        r.occ = OCC_W'(shadow_entries.size());
        return r;
    endfunction

    task automatic report_mismatch(input string what, input response_t want,
                                   input response_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t: %s: expected status %0d payload %h prio %0d occ %0d,",
                      " got status %0d payload %h prio %0d occ %0d"},
                     $realtime, what, want.status, want.data, want.prio, want.occ,
                     got.status, got.data, got.prio, got.occ);
    endtask

    always @(posedge clk)
    begin
        response_t got;
        response_t want;
        if (rst_n)
        begin
            if (req_mon.valid && req_mon.ready)
                owed_responses.push_back(apply_request(req_mon.req_type,
                                                       req_mon.priority_req,
                                                       req_mon.payload));
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                got.status = rsp_mon.status;
                got.data   = rsp_mon.out_payload;
                got.prio   = rsp_mon.out_priority;
                got.occ    = rsp_mon.occupancy;
                if (owed_responses.size() == 0)
                begin
                    report_mismatch("response with no request pending", '0, got);
                end
                else
                begin
                    want = owed_responses.pop_front();
                    if (got.status !== want.status || got.data !== want.data ||
                        got.prio !== want.prio || got.occ !== want.occ)
                        report_mismatch("response mismatch", want, got);
                end
            end
            responses_owed = owed_responses.size();
        end
    end

endmodule

/* tb/sv/stable_priority_queue_top_tb.sv */
// testbench top for the stable priority queue: clock, reset, request stimulus
// and response back-pressure; the verdict comes from spq_checker
// depends on spq_pkg, spq_if, spq_checker and stable_priority_queue_top
module stable_priority_queue_top_tb;
    import spq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int HOLD_CYCLES     = 80;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatch_count;
    int   responses_owed;
    bit   steady;
    int   holds_asked;
    int   holds_served;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    stable_priority_queue_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    spq_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_mon        (req_ch),
        .rsp_mon        (rsp_ch),
        .mismatch_count (mismatch_count),
        .responses_owed (responses_owed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // response side: random stalls, plus long hold-offs on request
    initial
    begin
        holds_served = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= steady || ($urandom_range(99) >= 18);
            end
        end
    end

    task automatic send_request(input logic kind, input logic [PRIO_PORT_W-1:0] prio,
                                input logic [PAYLOAD_W-1:0] data);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.priority_req <= prio;
        req_ch.payload      <= data;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        if (!steady && $urandom_range(99) < 18)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    function automatic logic [PRIO_PORT_W-1:0] pick_priority(input int style);
        case (style)
            0: return PRIO_PORT_W'($urandom_range(0, 3));
            1: return $urandom_range(1) ? '1 : '0;
            default: return PRIO_PORT_W'($urandom);
        endcase
    endfunction

    function automatic logic [PAYLOAD_W-1:0] pick_payload();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int  sent;
        int  phase;
        int  phase_len;
        int  enq_pct;
        int  style;
        int  biases[3];
        logic kind;

        biases = '{85, 15, 50};
        steady = 1'b0;
        holds_asked = 0;
        rst_n <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_ENQ;
        req_ch.priority_req <= '0;
        req_ch.payload      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // dequeue on empty, extremes, ties kept in arrival order
        send_request(REQ_DEQ, '1, '1);
        send_request(REQ_ENQ, 8'd0, 32'h0000_0000);
        send_request(REQ_ENQ, 8'd255, 32'hffff_ffff);
        send_request(REQ_ENQ, 8'h80, 32'ha5a5_a5a5);
        send_request(REQ_ENQ, 8'h80, 32'h5a5a_5a5a);
        send_request(REQ_ENQ, 8'd0, 32'h0000_0001);
        send_request(REQ_ENQ, 8'h7f, 32'h8000_0000);
        send_request(REQ_ENQ, 8'h81, 32'h7fff_ffff);
        repeat (7) send_request(REQ_DEQ, '0, '0);
        send_request(REQ_DEQ, '0, '0);
        send_request(REQ_ENQ, 8'h55, 32'h1234_5678);
        send_request(REQ_ENQ, 8'haa, 32'hfedc_ba98);
        send_request(REQ_DEQ, 8'haa, 32'h5555_5555);
        send_request(REQ_DEQ, 8'h55, 32'haaaa_aaaa);

        // phases alternate fill, drain and mixed traffic so full and empty recur
        sent = 0;
        phase = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            phase_len = $urandom_range(40, 120);
            enq_pct   = biases[phase % 3];
            style     = $urandom_range(2);
            steady   <= (phase >= 6 && phase < 9);
            if (phase == 3 || phase == 12)
                holds_asked++;
            repeat (phase_len)
            begin
                kind = ($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
                send_request(kind, pick_priority(style), pick_payload());
                sent++;
            end
            phase++;
        end
        req_ch.valid <= 1'b0;
        steady <= 1'b0;

        @(posedge clk);
        while (responses_owed != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_datapath.sv
rtl/spq_ctrl.sv
rtl/stable_priority_queue_top.sv
tb/sv/spq_checker.sv
tb/sv/stable_priority_queue_top_tb.sv
